[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mtfm_pkg.sv]
// Shared constants and types for the topic filter matcher.
package mtfm_pkg;

    localparam int FILTER_LEN = 64;
    localparam int ADDR_W     = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;
    localparam int PTR_W      = $clog2(FILTER_LEN + 1);
    localparam int POS_W      = 6;
    localparam int BYTE_W     = 8;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam byte_t CH_HASH  = 8'h23;
    localparam byte_t CH_PLUS  = 8'h2B;
    localparam byte_t CH_SLASH = 8'h2F;
    localparam byte_t CH_END   = 8'h00;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_TOPIC = 1'b1;

    // outcome of one filter step
    typedef enum logic [2:0] {
        STEP_CONSUME,
        STEP_CONT,
        STEP_FAIL,
        STEP_MATCH,
        STEP_ADV
    } step_t;

    typedef struct packed {
        logic take;   // idle, ready for an input transfer
        logic eval;   // apply one filter step
        logic emit;   // load result register and rearm
    } mtfm_cmd_t;

    typedef struct packed {
        logic in_fire;   // input transfer this cycle
        logic in_topic;  // that transfer is a topic byte
        logic step_cont; // step advanced and must run again
        logic t_end;     // current topic byte is the terminator
        logic out_free;  // result register can take a new result
    } mtfm_status_t;

endpackage

[rtl/mtfm_ctrl.sv]
// Sequencer for the topic filter matcher.
module mtfm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mtfm_pkg::mtfm_status_t st,
    output mtfm_pkg::mtfm_cmd_t    cmd
);
    import mtfm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_EVAL  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (st.in_fire && st.in_topic)
                begin
                    state_next = S_EVAL;
                end
            end
            S_FETCH:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (st.step_cont)
                begin
                    state_next = S_FETCH;
                end
                else if (st.t_end)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/mtfm_dp.sv]
// Filter store, match state and result register.
module mtfm_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mtfm_pkg::mtfm_cmd_t          cmd,
    output mtfm_pkg::mtfm_status_t       st,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        req_type,
    input  logic [mtfm_pkg::POS_W-1:0]  position,
    input  mtfm_pkg::byte_t              byte_value,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        matched
);
    import mtfm_pkg::*;

    byte_t mem [FILTER_LEN];
    byte_t rd_data_reg;

    ptr_t  ptr_reg;
    ptr_t  ptr_next;
    byte_t prev_reg;
    byte_t prev_next;
    logic  fail_reg;
    logic  fail_next;
    logic  match_reg;
    logic  match_next;
    byte_t topic_reg;
    logic  valid_reg;
    logic  valid_next;
    logic  matched_reg;
    logic  matched_next;

    logic  fire;
    logic  load_fire;
    byte_t f;
    logic  undecided;
    logic  lead_hash;
    logic  walk;
    logic  at_end;
    step_t step;

    assign item_stall = !cmd.take;
    assign fire       = item_valid && cmd.take;
    assign load_fire  = fire && (req_type == REQ_LOAD) && (int'(position) < FILTER_LEN);

    // filter store: one write port, one registered read port at the pointer
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            mem[ADDR_W'(position)] <= byte_value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[ptr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (fire && (req_type == REQ_TOPIC))
        begin
            topic_reg <= byte_value;
        end
    end

    // past the store end reads as terminator
    assign at_end    = (ptr_reg == PTR_W'(FILTER_LEN));
    assign f         = at_end ? CH_END : rd_data_reg;
    assign undecided = !fail_reg && !match_reg;
    assign lead_hash = (ptr_reg == '0) && (f == CH_HASH);
    assign walk      = undecided && !lead_hash;

    always_comb
    begin
        priority if ((f == CH_HASH) && (topic_reg != CH_END))
            step = STEP_CONSUME;
        else if ((f == CH_PLUS) && (topic_reg != CH_END) && (topic_reg != CH_SLASH))
            step = STEP_CONSUME;
        else if ((f == CH_PLUS) && (topic_reg == CH_SLASH))
            step = STEP_CONT;
        else if (((f == CH_HASH) || (f == CH_PLUS)) && (prev_reg != CH_SLASH))
            step = STEP_FAIL;
        else if (((f == CH_SLASH) || (f == CH_HASH) || (f == CH_PLUS))
                 && (topic_reg == CH_END))
            step = STEP_CONT;
        else if ((f == CH_END) && (topic_reg == CH_END))
            step = STEP_MATCH;
        else if (f == topic_reg)
            step = STEP_ADV;
        else
            step = STEP_FAIL;
    end

    always_comb
    begin
        ptr_next     = ptr_reg;
        prev_next    = prev_reg;
        fail_next    = fail_reg;
        match_next   = match_reg;
        valid_next   = valid_reg && result_stall;
        matched_next = matched_reg;
        if (cmd.eval)
        begin
            if (!walk)
            begin
                if (undecided)
                begin
                    match_next = 1'b1;
                end
            end
            else
            begin
                unique case (step)
                    STEP_CONT, STEP_ADV:
                    begin
                        prev_next = f;
                        if (!at_end)
                        begin
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                    STEP_FAIL:
                    begin
                        fail_next = 1'b1;
                    end
                    STEP_MATCH:
                    begin
                        match_next = 1'b1;
                    end
                    default:
                    begin
                        ptr_next = ptr_reg;
                    end
                endcase
            end
        end
        if (cmd.emit)
        begin
            valid_next   = 1'b1;
            matched_next = match_reg && !fail_reg;
            ptr_next     = '0;
            prev_next    = CH_END;
            fail_next    = 1'b0;
            match_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            prev_reg  <= CH_END;
            fail_reg  <= 1'b0;
            match_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            prev_reg  <= prev_next;
            fail_reg  <= fail_next;
            match_reg <= match_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    assign result_valid = valid_reg;
    assign matched      = matched_reg;

    assign st.in_fire   = fire;
    assign st.in_topic  = (req_type == REQ_TOPIC);
    assign st.step_cont = cmd.eval && walk && (step == STEP_CONT);
    assign st.t_end     = (topic_reg == CH_END);
    assign st.out_free  = !valid_reg || !result_stall;

endmodule

[rtl/mqtt_topic_filter_match.sv]
// Top level of the MQTT topic filter matcher (store, sequencer, datapath).
// Load transfers are accepted back to back. A topic byte is accepted in IDLE and
// gets one filter step in EVAL, plus a FETCH and EVAL pass per extra step on '+'
// before '/' or trailing wildcards. On the terminator EVAL goes to EMIT, which loads
// the result register. The filter store read port is registered, hence FETCH.
// rst_n clears pointer and decision flags; the filter store is not cleared.
module mqtt_topic_filter_match (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        req_type,
    input  logic [mtfm_pkg::POS_W-1:0]  position,
    input  mtfm_pkg::byte_t              byte_value,
    // result channel
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        matched
);
    import mtfm_pkg::*;

    // command and status between sequencer and datapath
    mtfm_cmd_t    cmd;
    mtfm_status_t st;

    // Sequencer: IDLE takes transfers; a topic byte goes to EVAL, which either
    // finishes the byte, loops through FETCH for another filter step, or moves
    // to EMIT on the terminator. EMIT waits for a free result register.
    mtfm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // Datapath: filter store, pointer, previous filter byte, decision flags
    // and the result register that decouples the output side.
    mtfm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .req_type     (req_type),
        .position     (position),
        .byte_value   (byte_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .matched      (matched)
    );

endmodule

[rtl/mtfm_checker.sv]
// Port-level checker for the topic filter matcher, with its bind.
`include "assert_macros.svh"

module mtfm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_stall,
    input logic                        req_type,
    input logic [mtfm_pkg::POS_W-1:0]  position,
    input mtfm_pkg::byte_t              byte_value,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic                        matched
);
    import mtfm_pkg::*;

    logic in_xfer;

    assign in_xfer = item_valid && !item_stall;

    `ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid, "result dropped while stalled")
    `ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(matched), "result changed while stalled")
    `ASSERT_NEXT(a_topic_busy, in_xfer && (req_type == REQ_TOPIC), item_stall, "topic byte not processed")
    `ASSERT_NEXT(a_load_free, in_xfer && (req_type == REQ_LOAD) && (position == position), !item_stall, "load transfer blocked input")
    `ASSERT_IMPL(a_term_busy, in_xfer && (req_type == REQ_TOPIC) && (byte_value == CH_END), ##1 item_stall ##1 item_stall, "terminator finished too early")

endmodule

bind mqtt_topic_filter_match mtfm_checker u_mtfm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .req_type     (req_type),
    .position     (position),
    .byte_value   (byte_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .matched      (matched)
);
